// ----- hdl/utfenc_pkg.sv -----
// Package for the code point to UTF-8 / UTF-16 encoder.
// Holds the field widths, the register indexes and the encoded-item struct.
// No dependencies.
`default_nettype none

package utfenc_pkg;

    localparam int CP_W       = 21;
    localparam int UNIT_W     = 16;
    localparam int CNT_OUT_W  = 16;
    localparam int CAP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY  = 2'd2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd256;

    localparam logic FORM_UTF8  = 1'b0;
    localparam logic FORM_UTF16 = 1'b1;

    // one code point, encoded: up to four units, n of them valid (1..4)
    typedef struct packed {
        logic [3:0][UNIT_W-1:0] units;
        logic [2:0]             n;
    } t_enc;

endpackage

`default_nettype wire

// ----- hdl/utfenc_in_if.sv -----
// Input channel of the encoder: one code point per beat.
// Depends on utfenc_pkg.
`default_nettype none

interface utfenc_in_if;
    import utfenc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

`default_nettype wire

// ----- hdl/utfenc_out_if.sv -----
// Result channel of the encoder: one unit or end-of-string record per beat.
// Depends on utfenc_pkg.
`default_nettype none

interface utfenc_out_if;
    import utfenc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [UNIT_W-1:0]    unit;
    logic                 is_terminator;
    logic [CNT_OUT_W-1:0] written_count;
    logic                 truncated;
    logic                 last;

    modport source (output valid, output unit, output is_terminator, output written_count,
                    output truncated, output last, input ready);
    modport sink   (input valid, input unit, input is_terminator, input written_count,
                    input truncated, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/utfenc_encode.sv -----
// Combinational encoder: one code point to 1..4 UTF-8 bytes or 1..2 UTF-16 units.
// Depends on utfenc_pkg.
`default_nettype none

module utfenc_encode (
    input  logic [utfenc_pkg::CP_W-1:0] i_code_point,
    input  logic                        i_form,
    output utfenc_pkg::t_enc            o_enc
);
    import utfenc_pkg::*;

    logic [CP_W-1:0] cp;

    assign cp = i_code_point;

    always_comb begin
        o_enc = '0;
        if (i_form == FORM_UTF16) begin
            if (cp > 21'h00FFFF) begin
                // surrogate pair; out-of-range values are not rejected
                o_enc.units[0] = UNIT_W'(cp[20:10]) + 16'hD7C0;
                o_enc.units[1] = 16'hDC00 | {6'b0, cp[9:0]};
                o_enc.n        = 3'd2;
            end else begin
                o_enc.units[0] = cp[15:0];
                o_enc.n        = 3'd1;
            end
        end else if (cp < 21'h000080) begin
            o_enc.units[0] = {9'b0, cp[6:0]};
            o_enc.n        = 3'd1;
        end else if (cp < 21'h000800) begin
            o_enc.units[0] = {8'b0, 3'b110, cp[10:6]};
            o_enc.units[1] = {8'b0, 2'b10, cp[5:0]};
            o_enc.n        = 3'd2;
        end else if (cp < 21'h010000) begin
            o_enc.units[0] = {8'b0, 3'b111, cp[16:12]};
            o_enc.units[1] = {8'b0, 2'b10, cp[11:6]};
            o_enc.units[2] = {8'b0, 2'b10, cp[5:0]};
            o_enc.n        = 3'd3;
        end else begin
            o_enc.units[0] = {8'b0, 5'b11110, cp[20:18]};
            o_enc.units[1] = {8'b0, 2'b10, cp[17:12]};
            o_enc.units[2] = {8'b0, 2'b10, cp[11:6]};
            o_enc.units[3] = {8'b0, 2'b10, cp[5:0]};
            o_enc.n        = 3'd4;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/codepoint_to_utf8_utf16_encoder.sv -----
// Code point to UTF-8 / UTF-16 encoder. A code point is encoded as it is
// accepted and held in the emit stage, which sends one result beat per cycle
// through an output register unless the output stalls. An item leaves the emit
// stage once its units (1 to 4 in UTF-8, 1 to 2 in UTF-16) are sent or the
// output is full; one that yields none (count-only mode, full output) leaves
// with no beat. The single result channel sets the rate; a new code point is
// taken in the cycle the previous one leaves the emit stage. Code point zero
// closes a string with one end beat carrying the count and the truncated flag.
// Depends on utfenc_pkg, utfenc_in_if, utfenc_out_if and utfenc_encode.
`default_nettype none

module codepoint_to_utf8_utf16_encoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [utfenc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [utfenc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    utfenc_in_if.sink                         i_in,
    utfenc_out_if.source                      o_out
);
    import utfenc_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

    // output is full once count reaches capacity-1; never in count-only mode
    function automatic logic f_full(input logic [COUNT_BITS-1:0] cnt,
                                    input logic [CAP_W-1:0]      cap,
                                    input logic                  cnt_only);
        logic [CMP_W-1:0] cnt_ext;
        logic [CMP_W-1:0] lim;
        cnt_ext = CMP_W'(cnt);
        lim     = CMP_W'(cap - CAP_W'(1));
        return !cnt_only && ((cap == '0) || (cnt_ext >= lim));
    endfunction

    // configuration
    logic [CAP_W-1:0] r_capacity;
    logic             r_form;
    logic             r_count_only;

    // emit stage
    logic                  r_em_valid;
    t_enc                  r_enc;
    logic                  r_em_end;
    logic [1:0]            r_idx;
    logic [COUNT_BITS-1:0] r_count;

    // output register
    logic                 r_out_valid;
    logic [UNIT_W-1:0]    r_out_unit;
    logic                 r_out_term;
    logic [CNT_OUT_W-1:0] r_out_count;
    logic                 r_out_trunc;
    logic                 r_out_last;

    t_enc                  w_enc;
    logic                  w_out_free;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [COUNT_BITS:0]   w_sum;
    logic [COUNT_BITS-1:0] w_cnt_sat;
    logic                  w_full_now;
    logic                  w_full_next;
    logic                  w_unit_last;
    logic                  w_emits;
    logic                  w_step;
    logic                  w_done;
    logic                  w_in_beat;

    utfenc_encode u_encode (
        .i_code_point (i_in.code_point),
        .i_form       (r_form),
        .o_enc        (w_enc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RESET;
            r_form       <= FORM_UTF8;
            r_count_only <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_CAPACITY:    r_capacity   <= i_cfg_data;
                CFG_OUTPUT_FORM: r_form       <= i_cfg_data[0];
                CFG_COUNT_ONLY:  r_count_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_cnt_inc   = r_count + COUNT_BITS'(1);
    assign w_sum       = {1'b0, r_count} + (COUNT_BITS+1)'(r_enc.n);
    assign w_cnt_sat   = w_sum[COUNT_BITS] ? '1 : w_sum[COUNT_BITS-1:0];
    assign w_full_now  = f_full(r_count, r_capacity, r_count_only);
    assign w_full_next = f_full(w_cnt_inc, r_capacity, r_count_only);
    assign w_unit_last = ({1'b0, r_idx} == (r_enc.n - 3'd1));

    // a beat goes out for the end record and, outside count-only mode, for each unit that still fits
    assign w_emits = r_em_valid && (r_em_end || (!r_count_only && !w_full_now));
    assign w_step  = r_em_valid && (w_out_free || !w_emits);
    assign w_done  = w_step && (r_em_end || r_count_only || w_full_now
                                || w_unit_last || w_full_next);

    assign i_in.ready = !r_em_valid || w_done;
    assign w_in_beat  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid  <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_beat) begin
                r_em_valid <= 1'b1;
                r_idx      <= '0;
            end else if (w_done) begin
                r_em_valid <= 1'b0;
            end else if (w_step) begin
                r_idx <= r_idx + 2'd1;
            end

            if (w_step) begin
                if (r_em_end) begin
                    r_count <= '0;
                end else if (r_count_only) begin
                    r_count <= w_cnt_sat;
                end else if (!w_full_now) begin
                    r_count <= w_cnt_inc;
                end
            end

            if (w_step && w_emits) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_enc    <= w_enc;
            r_em_end <= (i_in.code_point == '0);
        end
        if (w_step && w_emits) begin
            if (r_em_end) begin
                r_out_unit  <= '0;
                r_out_term  <= !r_count_only && (r_capacity != '0);
                r_out_count <= CNT_OUT_W'(r_count);
                r_out_trunc <= w_full_now;
                r_out_last  <= 1'b1;
            end else begin
                r_out_unit  <= r_enc.units[r_idx];
                r_out_term  <= 1'b0;
                r_out_count <= CNT_OUT_W'(w_cnt_inc);
                r_out_trunc <= w_full_next;
                // a unit that fills the output ends the item early
                r_out_last  <= w_unit_last || w_full_next;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.unit          = r_out_unit;
    assign o_out.is_terminator = r_out_term;
    assign o_out.written_count = r_out_count;
    assign o_out.truncated     = r_out_trunc;
    assign o_out.last          = r_out_last;

endmodule

`default_nettype wire

// ----- tb/codepoint_to_utf8_utf16_encoder_test.sv -----
// Self-checking bench for codepoint_to_utf8_utf16_encoder: drives code points,
// predicts each unit / end beat in a local encoder model and compares in order.
// Depends on utfenc_pkg, utfenc_in_if, utfenc_out_if and the encoder RTL.
`default_nettype none

module codepoint_to_utf8_utf16_encoder_test;
    import utfenc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int COUNT_LIMIT = 65535;

    typedef struct {
        logic [UNIT_W-1:0]    unit;
        logic                 is_terminator;
        logic [CNT_OUT_W-1:0] written_count;
        logic                 truncated;
        logic                 last;
    } unit_beat_t;

    // Predicts the unit stream from accepted code points and checks the beats.
    class utf_unit_checker;
        logic [CAP_W-1:0] capacity = CAPACITY_RESET;
        logic             output_form = FORM_UTF8;
        logic             count_only = 1'b0;
        int               units_in_string = 0;
        unit_beat_t       pending_units[$];
        int               errors = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CAPACITY:    capacity = data[CAP_W-1:0];
                CFG_OUTPUT_FORM: output_form = data[0];
                CFG_COUNT_ONLY:  count_only = data[0];
                default: ;
            endcase
        endfunction

        function bit buffer_full();
            if (count_only)
                return 1'b0;
            if (capacity == 0)
                return 1'b1;
            return units_in_string >= int'(capacity) - 1;
        endfunction

        function void encode_code_point(logic [CP_W-1:0] cp);
            logic [UNIT_W-1:0] u [4];
            logic [CP_W-1:0]   c;
            logic [7:0]        lead;
            int                n;
            unit_beat_t        b;

            if (cp == 0) begin
                b.unit = '0;
                b.is_terminator = !count_only && capacity >= 1;
                b.written_count = units_in_string[CNT_OUT_W-1:0];
                b.truncated = buffer_full();
                b.last = 1'b1;
                pending_units.push_back(b);
                units_in_string = 0;
                return;
            end

            if (output_form == FORM_UTF16) begin
                if (cp > 21'hFFFF) begin
                    u[0] = UNIT_W'((cp >> 10) + 21'hD7C0);
                    u[1] = UNIT_W'(cp[9:0] + 21'hDC00);
                    n = 2;
                end else begin
                    u[0] = cp[15:0];
                    n = 1;
                end
            end else if (cp < 21'h80) begin
                u[0] = UNIT_W'(cp);
                n = 1;
            end else begin
                n = 2 + int'(cp >= 21'h800) + int'(cp >= 21'h10000);
                c = cp;
                for (int i = n - 1; i > 0; i--) begin
                    u[i] = {8'h00, 2'b10, c[5:0]};
                    c = c >> 6;
                end
                lead = (n == 2) ? 8'hC0 : (n == 3) ? 8'hE0 : 8'hF0;
                u[0] = {8'h00, lead | {3'b000, c[4:0]}};
            end

            if (count_only) begin
                units_in_string += n;
                if (units_in_string > COUNT_LIMIT)
                    units_in_string = COUNT_LIMIT;
                return;
            end

            for (int i = 0; i < n; i++) begin
                if (buffer_full())
                    break;
                units_in_string = (units_in_string + 1) & COUNT_LIMIT;
                b.unit = u[i];
                b.is_terminator = 1'b0;
                b.written_count = units_in_string[CNT_OUT_W-1:0];
                b.truncated = buffer_full();
                b.last = (i == n - 1) || buffer_full();
                pending_units.push_back(b);
            end
        endfunction

        function void compare_unit_beat(unit_beat_t got);
            unit_beat_t want;
            if (pending_units.size() == 0) begin
                $error("unexpected beat: unit %h last %b", got.unit, got.last);
                errors++;
                return;
            end
            want = pending_units.pop_front();
            if (got.unit !== want.unit) begin
                $error("unit: expected %h, got %h", want.unit, got.unit);
                errors++;
            end
            if (got.is_terminator !== want.is_terminator) begin
                $error("is_terminator: expected %b, got %b",
                       want.is_terminator, got.is_terminator);
                errors++;
            end
            if (got.written_count !== want.written_count) begin
                $error("written_count: expected %0d, got %0d",
                       want.written_count, got.written_count);
                errors++;
            end
            if (got.truncated !== want.truncated) begin
                $error("truncated: expected %b, got %b", want.truncated, got.truncated);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_units.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    bit steady = 1'b0;   // no gaps or stalls while set

    utfenc_in_if  cp_ch ();
    utfenc_out_if unit_ch ();

    utf_unit_checker checker_h = new();

    codepoint_to_utf8_utf16_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (cp_ch),
        .o_out       (unit_ch)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        cp_ch.valid = 1'b0;
        cp_ch.code_point = '0;
        unit_ch.ready = 1'b0;
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        checker_h.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input int cap, input bit form, input bit cnt_only);
        set_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
        set_reg(CFG_OUTPUT_FORM, {{(CFG_DATA_W-1){1'b0}}, form});
        set_reg(CFG_COUNT_ONLY, {{(CFG_DATA_W-1){1'b0}}, cnt_only});
    endtask

    task automatic send_code_point(input logic [CP_W-1:0] cp);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            cp_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cp_ch.valid = 1'b1;
        cp_ch.code_point = cp;
        do @(posedge i_clk); while (!cp_ch.ready);
        checker_h.encode_code_point(cp);
        @(negedge i_clk);
    endtask

    // Hold off input until every predicted beat is in, then let a silent item finish.
    task automatic wait_results();
        cp_ch.valid = 1'b0;
        do @(posedge i_clk); while (checker_h.pending() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [CP_W-1:0] random_code_point();
        case ($urandom_range(0, 4))
            0: return CP_W'($urandom_range(1, 'h7F));
            1: return CP_W'($urandom_range('h80, 'h7FF));
            2: return CP_W'($urandom_range('h800, 'hFFFF));
            3: return CP_W'($urandom_range('h10000, 'h10FFFF));
            default: return CP_W'($urandom_range(1, 'h10FFFF));
        endcase
    endfunction

    function automatic int random_capacity();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 3;
            4: return 65535;
            5: return 256;
            default: return $urandom_range(4, 24);
        endcase
    endfunction

    // Result side: random stall before each beat.
    initial begin
        int stall;
        unit_beat_t got;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                unit_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            unit_ch.ready = 1'b1;
            do @(posedge i_clk); while (unit_ch.valid !== 1'b1);
            got.unit = unit_ch.unit;
            got.is_terminator = unit_ch.is_terminator;
            got.written_count = unit_ch.written_count;
            got.truncated = unit_ch.truncated;
            got.last = unit_ch.last;
            checker_h.compare_unit_beat(got);
            @(negedge i_clk);
        end
    end

    initial begin
        #2000000;
        $display("codepoint_to_utf8_utf16_encoder verification failed");
        $finish;
    end

    initial begin
        logic [CP_W-1:0] edge_points [11] = '{
            21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFFF, 21'h10000,
            21'h10FFFF, 21'hD800, 21'h1, 21'h110000, 21'h1FFFFF
        };
        int random_items;
        int len;
        bit close_string;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset config: UTF-8, capacity 256; length boundaries, surrogate, past-range values
        foreach (edge_points[i])
            send_code_point(edge_points[i]);
        send_code_point('0);
        wait_results();

        // UTF-16 pairs, including the out-of-range pair
        set_config(256, FORM_UTF16, 1'b0);
        send_code_point(21'h10000);
        send_code_point(21'h1FFFFF);
        send_code_point(21'hDFFF);
        wait_results();
        // form switches mid-string
        set_reg(CFG_OUTPUT_FORM, {{(CFG_DATA_W-1){1'b0}}, FORM_UTF8});
        send_code_point(21'h10000);
        send_code_point('0);
        wait_results();

        // zero capacity: full from the start, no terminator
        set_config(0, FORM_UTF8, 1'b0);
        send_code_point(21'h41);
        send_code_point('0);
        wait_results();

        // capacity 1: only the terminator fits
        set_reg(CFG_CAPACITY, 16'd1);
        send_code_point('0);
        wait_results();

        // capacity 3: four-byte sequence cut after two bytes, exact fill, rest ignored
        set_reg(CFG_UNUSED, 16'hFFFF);
        set_reg(CFG_CAPACITY, 16'd3);
        send_code_point(21'h10FFFF);
        send_code_point(21'h41);
        send_code_point('0);
        wait_results();

        // count-only: silent items, one end beat
        set_config(2, FORM_UTF8, 1'b1);
        send_code_point(21'h10FFFF);
        send_code_point(21'h41);
        send_code_point('0);
        wait_results();

        random_items = 0;
        while (random_items < 135) begin
            set_config(random_capacity(), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0)
                set_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            steady = ($urandom_range(0, 3) == 0);
            len = $urandom_range(0, 12);
            for (int j = 0; j < len; j++) begin
                send_code_point(random_code_point());
                random_items++;
                if (j == len / 2 && $urandom_range(0, 5) == 0)
                    wait_results();
            end
            // leaving a string open carries it across the next register change
            close_string = ($urandom_range(0, 5) != 0);
            if (close_string) begin
                send_code_point('0);
                random_items++;
            end
            wait_results();
        end
        steady = 1'b0;
        send_code_point('0);
        wait_results();
        repeat (20) @(negedge i_clk);

        if (checker_h.errors == 0 && checker_h.pending() == 0) begin
            $display("codepoint_to_utf8_utf16_encoder verification clean");
        end else begin
            $display("codepoint_to_utf8_utf16_encoder verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
